FILE: hw/rtl/battery_pack_power_sequencer_defines.svh
// ----------------------------------------------------------------------------
// battery pack power sequencer assertion macros
// shared concurrent assertion forms for the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef BATTERY_PACK_POWER_SEQUENCER_DEFINES_SVH
`define BATTERY_PACK_POWER_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BPPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BPPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bpps_pkg.sv
// ----------------------------------------------------------------------------
// bpps_pkg
// types, codes and reset values shared by the power sequencer modules
// ----------------------------------------------------------------------------
package bpps_pkg;

	typedef enum logic [2:0] {
		ST_INIT = 3'd0,
		ST_OFF  = 3'd1,
		ST_PRE  = 3'd2,
		ST_ON   = 3'd3,
		ST_ERR  = 3'd4
	} state_e_t;

	typedef enum logic [2:0] {
		PH_INTERLOCK = 3'd0,
		PH_ADDRESS   = 3'd1,
		PH_SETUP     = 3'd2,
		PH_CAPACITY  = 3'd3,
		PH_CALIBRATE = 3'd4,
		PH_START     = 3'd5
	} phase_t;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_EXPECTED_SLAVES = 2'd0;
	localparam logic [1:0] CFG_OFF_PERIOD      = 2'd1;
	localparam logic [1:0] CFG_PRECHARGE_TIME  = 2'd2;
	localparam logic [1:0] CFG_QUIT_ERROR_TIME = 2'd3;

	localparam logic [5:0]  RST_EXPECTED_SLAVES = 6'd8;
	localparam logic [15:0] RST_OFF_PERIOD      = 16'd1000;
	localparam logic [15:0] RST_PRECHARGE_TIME  = 16'd2000;
	localparam logic [15:0] RST_QUIT_ERROR_TIME = 16'd3000;

	// calibration status codes
	localparam logic [1:0] CAL_BUSY = 2'd0;
	localparam logic [1:0] CAL_OK   = 2'd1;

	// action strobes
	localparam int unsigned ACT_W = 13;
	localparam logic [ACT_W-1:0] A_QUIT   = 13'h0001;
	localparam logic [ACT_W-1:0] A_ADDR   = 13'h0002;
	localparam logic [ACT_W-1:0] A_SETUP  = 13'h0004;
	localparam logic [ACT_W-1:0] A_CAP    = 13'h0008;
	localparam logic [ACT_W-1:0] A_CAL    = 13'h0010;
	localparam logic [ACT_W-1:0] A_TIMERS = 13'h0020;
	localparam logic [ACT_W-1:0] A_SLEEP  = 13'h0040;
	localparam logic [ACT_W-1:0] A_MEAS   = 13'h0080;
	localparam logic [ACT_W-1:0] A_MAIN   = 13'h0100;
	localparam logic [ACT_W-1:0] A_PRECH  = 13'h0200;
	localparam logic [ACT_W-1:0] A_TRIP   = 13'h0400;
	localparam logic [ACT_W-1:0] A_CLEAR  = 13'h0800;
	localparam logic [ACT_W-1:0] A_PROT   = 13'h1000;

	typedef struct packed {
		logic [5:0]  expected_slaves;
		logic [15:0] off_update_period_ms;
		logic [15:0] precharge_time_ms;
		logic [15:0] quit_error_time_ms;
	} cfg_t;

	typedef struct packed {
		state_e_t    main;
		logic [2:0]  init_phase;
		logic [31:0] last_off_update;
		logic [31:0] precharge_entry_time;
		logic        precharge_fresh;
		logic        off_held;
		logic [31:0] off_hold_start;
	} seq_state_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        interlock_tripped;
		logic        on_pin_level;
		logic        off_pin_level;
		logic        stale_data;
		logic        stale_data_off;
		logic [4:0]  limit_faults;
		logic [5:0]  slaves_found;
		logic        measure_init_ok;
		logic [1:0]  calib_status;
		logic        timer_start_error;
		logic        wheel_speed_error;
	} tick_t;

	typedef struct packed {
		logic [2:0]       shown_state;
		logic [2:0]       next_state;
		logic [2:0]       init_phase_out;
		logic [ACT_W-1:0] action_mask;
	} result_t;

endpackage

FILE: hw/rtl/bpps_step.sv
// ----------------------------------------------------------------------------
// bpps_step
// next-state and action logic for one run tick of the power sequencer
// ----------------------------------------------------------------------------
module bpps_step (
	input  bpps_pkg::cfg_t       cfg,
	input  bpps_pkg::seq_state_t st,
	input  bpps_pkg::tick_t      tick,
	output bpps_pkg::seq_state_t st_next,
	output bpps_pkg::result_t    res
);

	bpps_pkg::state_e_t          shown;
	bpps_pkg::state_e_t          eff;
	bpps_pkg::state_e_t          nxt;
	logic [bpps_pkg::ACT_W-1:0]  act;
	logic [31:0]                 off_delta;
	logic [31:0]                 pre_delta;
	logic [31:0]                 hold_delta;
	logic                        ilk;

	assign ilk        = tick.interlock_tripped;
	assign off_delta  = tick.now_ms - st.last_off_update;
	assign pre_delta  = tick.now_ms - st.precharge_entry_time;
	assign hold_delta = tick.now_ms - st.off_hold_start;

	always_comb begin
		st_next = st;
		act     = '0;
		nxt     = bpps_pkg::ST_INIT;

		unique case (st.main)
			bpps_pkg::ST_OFF, bpps_pkg::ST_PRE, bpps_pkg::ST_ON, bpps_pkg::ST_ERR: begin
				shown = st.main;
			end
			default: begin
				shown = bpps_pkg::ST_INIT;
			end
		endcase

		// limit protector runs in the operating states and can force error
		eff = shown;
		if (shown == bpps_pkg::ST_OFF || shown == bpps_pkg::ST_PRE
				|| shown == bpps_pkg::ST_ON) begin
			act = act | bpps_pkg::A_PROT;
			if ((shown == bpps_pkg::ST_OFF && tick.stale_data_off)
					|| (shown != bpps_pkg::ST_OFF && tick.stale_data)
					|| (tick.limit_faults != '0)) begin
				eff = bpps_pkg::ST_ERR;
			end
		end

		unique case (eff)
			bpps_pkg::ST_OFF: begin
				act = act | bpps_pkg::A_SLEEP;
				if (ilk) begin
					nxt = bpps_pkg::ST_ERR;
				end else begin
					if (off_delta >= {16'd0, cfg.off_update_period_ms}) begin
						act = act | bpps_pkg::A_MEAS;
						st_next.last_off_update = tick.now_ms;
					end
					nxt = (tick.on_pin_level && tick.off_pin_level)
						? bpps_pkg::ST_PRE : bpps_pkg::ST_OFF;
				end
			end
			bpps_pkg::ST_PRE: begin
				if (st.precharge_fresh) begin
					st_next.precharge_entry_time = tick.now_ms;
					act = act | bpps_pkg::A_MAIN;
				end
				act = act | bpps_pkg::A_MEAS;
				st_next.precharge_fresh = 1'b1;
				// a fresh entry skips the switch-on check, as its entry time is only now captured
				priority if (ilk) begin
					nxt = bpps_pkg::ST_ERR;
				end else if (!tick.off_pin_level) begin
					nxt = bpps_pkg::ST_OFF;
				end else if (!st.precharge_fresh
						&& pre_delta > {16'd0, cfg.precharge_time_ms}) begin
					nxt = bpps_pkg::ST_ON;
				end else begin
					st_next.precharge_fresh = 1'b0;
					nxt = bpps_pkg::ST_PRE;
				end
			end
			bpps_pkg::ST_ON: begin
				act = act | bpps_pkg::A_PRECH | bpps_pkg::A_MEAS;
				priority if (ilk) begin
					nxt = bpps_pkg::ST_ERR;
				end else if (!tick.off_pin_level) begin
					nxt = bpps_pkg::ST_OFF;
				end else begin
					nxt = bpps_pkg::ST_ON;
				end
			end
			bpps_pkg::ST_ERR: begin
				act = act | bpps_pkg::A_TRIP;
				nxt = bpps_pkg::ST_ERR;
				if (!tick.off_pin_level) begin
					if (st.off_held) begin
						if (hold_delta > {16'd0, cfg.quit_error_time_ms}) begin
							act = act | bpps_pkg::A_CLEAR;
							nxt = bpps_pkg::ST_INIT;
						end
					end else begin
						st_next.off_hold_start = tick.now_ms;
						st_next.off_held = 1'b1;
					end
				end else begin
					st_next.off_held = 1'b0;
				end
			end
			default: begin
				nxt = bpps_pkg::ST_INIT;
				if (st.init_phase != 3'(bpps_pkg::PH_INTERLOCK) && ilk) begin
					st_next.init_phase = 3'(bpps_pkg::PH_INTERLOCK);
					nxt = bpps_pkg::ST_ERR;
				end else begin
					unique case (st.init_phase)
						3'(bpps_pkg::PH_INTERLOCK): begin
							act = act | bpps_pkg::A_QUIT;
							if (ilk) begin
								nxt = bpps_pkg::ST_ERR;
							end else begin
								st_next.init_phase = 3'(bpps_pkg::PH_ADDRESS);
							end
						end
						3'(bpps_pkg::PH_ADDRESS): begin
							act = act | bpps_pkg::A_ADDR;
							if (tick.slaves_found == cfg.expected_slaves) begin
								st_next.init_phase = 3'(bpps_pkg::PH_SETUP);
							end
						end
						3'(bpps_pkg::PH_SETUP): begin
							act = act | bpps_pkg::A_SETUP;
							st_next.init_phase = 3'(bpps_pkg::PH_CAPACITY);
						end
						3'(bpps_pkg::PH_CAPACITY): begin
							act = act | bpps_pkg::A_CAP;
							if (tick.measure_init_ok) begin
								st_next.init_phase = 3'(bpps_pkg::PH_CALIBRATE);
							end
						end
						3'(bpps_pkg::PH_CALIBRATE): begin
							act = act | bpps_pkg::A_CAL;
							if (tick.calib_status != bpps_pkg::CAL_BUSY
									&& tick.calib_status != bpps_pkg::CAL_OK) begin
								nxt = bpps_pkg::ST_ERR;
							end else if (tick.calib_status == bpps_pkg::CAL_OK) begin
								st_next.init_phase = 3'(bpps_pkg::PH_START);
							end
						end
						3'(bpps_pkg::PH_START): begin
							act = act | bpps_pkg::A_TIMERS;
							if (tick.timer_start_error || tick.wheel_speed_error) begin
								nxt = bpps_pkg::ST_ERR;
							end else begin
								st_next.init_phase = 3'(bpps_pkg::PH_INTERLOCK);
								nxt = bpps_pkg::ST_OFF;
							end
						end
						default: begin
							// unused phase codes fall back to the first phase
							st_next.init_phase = 3'(bpps_pkg::PH_INTERLOCK);
						end
					endcase
				end
			end
		endcase

		st_next.main       = nxt;
		res.shown_state    = shown;
		res.next_state     = nxt;
		res.init_phase_out = st_next.init_phase;
		res.action_mask    = act;
	end

endmodule

FILE: hw/rtl/battery_pack_power_sequencer.sv
// ----------------------------------------------------------------------------
// battery_pack_power_sequencer
// main state sequencer of a battery pack, one result per accepted run tick
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  tick      in_valid / in_ready + tick fields    in
//  result    out_valid / out_ready + result       out
//  config    cfg_we, cfg_index, cfg_data          in
//
// a tick is decided in the cycle of its transfer; its result is registered
// in the output register, or in the skid while the output stalls, so
// one tick per cycle while the skid is empty; the state registers feed
// the step logic directly, so consecutive ticks chain; a two-entry output
// buffer (output register plus skid) drops ready only while the skid is full
// reset puts the sequencer in init, first phase, with register defaults
// ----------------------------------------------------------------------------
`include "battery_pack_power_sequencer_defines.svh"

module battery_pack_power_sequencer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic        interlock_tripped,
	input  logic        on_pin_level,
	input  logic        off_pin_level,
	input  logic        stale_data,
	input  logic        stale_data_off,
	input  logic [4:0]  limit_faults,
	input  logic [5:0]  slaves_found,
	input  logic        measure_init_ok,
	input  logic [1:0]  calib_status,
	input  logic        timer_start_error,
	input  logic        wheel_speed_error,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  shown_state,
	output logic [2:0]  next_state,
	output logic [2:0]  init_phase_out,
	output logic [12:0] action_mask,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	bpps_pkg::cfg_t       cfg_q;
	bpps_pkg::seq_state_t st_q;
	bpps_pkg::seq_state_t st_next;
	bpps_pkg::tick_t      tick;
	bpps_pkg::result_t    res;
	bpps_pkg::result_t    out_data_q;
	bpps_pkg::result_t    skid_data_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;
	logic                 in_fire;
	logic                 out_fire;
	logic                 load_out_new;
	logic                 load_out_skid;
	logic                 load_skid;

	assign tick.now_ms            = now_ms;
	assign tick.interlock_tripped = interlock_tripped;
	assign tick.on_pin_level      = on_pin_level;
	assign tick.off_pin_level     = off_pin_level;
	assign tick.stale_data        = stale_data;
	assign tick.stale_data_off    = stale_data_off;
	assign tick.limit_faults      = limit_faults;
	assign tick.slaves_found      = slaves_found;
	assign tick.measure_init_ok   = measure_init_ok;
	assign tick.calib_status      = calib_status;
	assign tick.timer_start_error = timer_start_error;
	assign tick.wheel_speed_error = wheel_speed_error;

	bpps_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.tick    (tick),
		.st_next (st_next),
		.res     (res)
	);

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	// skid drains first; a new transfer goes to whichever slot is free
	assign load_out_skid = skid_valid_q && out_fire;
	assign load_out_new  = in_fire && (!out_valid_q || out_fire);
	assign load_skid     = in_fire && out_valid_q && !out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_slaves      <= bpps_pkg::RST_EXPECTED_SLAVES;
			cfg_q.off_update_period_ms <= bpps_pkg::RST_OFF_PERIOD;
			cfg_q.precharge_time_ms    <= bpps_pkg::RST_PRECHARGE_TIME;
			cfg_q.quit_error_time_ms   <= bpps_pkg::RST_QUIT_ERROR_TIME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpps_pkg::CFG_EXPECTED_SLAVES: cfg_q.expected_slaves      <= cfg_data[5:0];
				bpps_pkg::CFG_OFF_PERIOD:      cfg_q.off_update_period_ms <= cfg_data;
				bpps_pkg::CFG_PRECHARGE_TIME:  cfg_q.precharge_time_ms    <= cfg_data;
				bpps_pkg::CFG_QUIT_ERROR_TIME: cfg_q.quit_error_time_ms   <= cfg_data;
				default:                       cfg_q.quit_error_time_ms   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.main                 <= bpps_pkg::ST_INIT;
			st_q.init_phase           <= 3'(bpps_pkg::PH_INTERLOCK);
			st_q.last_off_update      <= '0;
			st_q.precharge_entry_time <= '0;
			st_q.precharge_fresh      <= 1'b1;
			st_q.off_held             <= 1'b0;
			st_q.off_hold_start       <= '0;
		end else if (in_fire) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (load_out_skid || load_out_new) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (load_out_skid) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_skid) begin
			out_data_q <= skid_data_q;
		end else if (load_out_new) begin
			out_data_q <= res;
		end
		if (load_skid) begin
			skid_data_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign shown_state    = out_data_q.shown_state;
	assign next_state     = out_data_q.next_state;
	assign init_phase_out = out_data_q.init_phase_out;
	assign action_mask    = out_data_q.action_mask;

	`BPPS_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid holds a result while the output register is empty")
	`BPPS_ASSERT_NEXT(a_stall_fills_skid, clk, arst_n, in_fire && out_valid_q && !out_ready, skid_valid_q, "stalled transfer not captured in skid")
	`BPPS_ASSERT_NEXT(a_state_follows, clk, arst_n, in_fire, st_q.main == $past(res.next_state), "main state differs from reported next state")

endmodule

FILE: sim/bpps_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpps_result_checker
// watches the tick and result channels of the power sequencer, predicts every
// result from its own copy of the sequencer state and registers, and compares
// each arriving result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module bpps_result_checker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic        interlock_tripped,
	input  logic        on_pin_level,
	input  logic        off_pin_level,
	input  logic        stale_data,
	input  logic        stale_data_off,
	input  logic [4:0]  limit_faults,
	input  logic [5:0]  slaves_found,
	input  logic        measure_init_ok,
	input  logic [1:0]  calib_status,
	input  logic        timer_start_error,
	input  logic        wheel_speed_error,

	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  shown_state,
	input  logic [2:0]  next_state,
	input  logic [2:0]  init_phase_out,
	input  logic [12:0] action_mask,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	output int unsigned mismatches,
	output int unsigned results_checked,
	output int unsigned outcomes_due,
	output int unsigned switch_ons,
	output int unsigned error_exits
);

	localparam int unsigned MISMATCH_REPORTS = 10;

	bpps_pkg::cfg_t       regs;
	bpps_pkg::seq_state_t seq;
	bpps_pkg::result_t    tick_outcomes_due[$];

	// one run tick of the sequencer, updates seq and returns the result
	function automatic bpps_pkg::result_t step_sequencer(input bpps_pkg::tick_t t);
		bpps_pkg::result_t          r;
		bpps_pkg::state_e_t         cur;
		bpps_pkg::state_e_t         nxt;
		logic [bpps_pkg::ACT_W-1:0] act;
		logic [31:0]                elapsed;
		logic                       stale_hit;

		act = '0;
		cur = seq.main;
		nxt = cur;
		r.shown_state = cur;

		// limit and staleness check only while running
		if (cur != bpps_pkg::ST_INIT && cur != bpps_pkg::ST_ERR) begin
			act |= bpps_pkg::A_PROT;
			stale_hit = (cur == bpps_pkg::ST_OFF) ? t.stale_data_off : t.stale_data;
			if (stale_hit || t.limit_faults != '0)
				cur = bpps_pkg::ST_ERR;
		end

		case (cur)
			bpps_pkg::ST_OFF: begin
				act |= bpps_pkg::A_SLEEP;
				if (t.interlock_tripped) begin
					nxt = bpps_pkg::ST_ERR;
				end else begin
					elapsed = t.now_ms - seq.last_off_update;
					if (elapsed >= {16'd0, regs.off_update_period_ms}) begin
						act |= bpps_pkg::A_MEAS;
						seq.last_off_update = t.now_ms;
					end
					nxt = (t.on_pin_level && t.off_pin_level)
						? bpps_pkg::ST_PRE : bpps_pkg::ST_OFF;
				end
			end
			bpps_pkg::ST_PRE: begin
				if (seq.precharge_fresh) begin
					seq.precharge_entry_time = t.now_ms;
					act |= bpps_pkg::A_MAIN;
				end
				act |= bpps_pkg::A_MEAS;
				seq.precharge_fresh = 1'b1;
				elapsed = t.now_ms - seq.precharge_entry_time;
				if (t.interlock_tripped) begin
					nxt = bpps_pkg::ST_ERR;
				end else if (!t.off_pin_level) begin
					nxt = bpps_pkg::ST_OFF;
				end else if (elapsed > {16'd0, regs.precharge_time_ms}) begin
					nxt = bpps_pkg::ST_ON;
				end else begin
					seq.precharge_fresh = 1'b0;
					nxt = bpps_pkg::ST_PRE;
				end
			end
			bpps_pkg::ST_ON: begin
				act |= bpps_pkg::A_PRECH | bpps_pkg::A_MEAS;
				if (t.interlock_tripped)
					nxt = bpps_pkg::ST_ERR;
				else if (!t.off_pin_level)
					nxt = bpps_pkg::ST_OFF;
				else
					nxt = bpps_pkg::ST_ON;
			end
			bpps_pkg::ST_ERR: begin
				act |= bpps_pkg::A_TRIP;
				nxt = bpps_pkg::ST_ERR;
				if (!t.off_pin_level) begin
					if (seq.off_held) begin
						elapsed = t.now_ms - seq.off_hold_start;
						if (elapsed > {16'd0, regs.quit_error_time_ms}) begin
							act |= bpps_pkg::A_CLEAR;
							nxt = bpps_pkg::ST_INIT;
						end
					end else begin
						seq.off_hold_start = t.now_ms;
						seq.off_held = 1'b1;
					end
				end else begin
					seq.off_held = 1'b0;
				end
			end
			default: begin
				nxt = bpps_pkg::ST_INIT;
				// interlock past the first phase restarts the sequence, no strobe
				if (seq.init_phase != bpps_pkg::PH_INTERLOCK && t.interlock_tripped) begin
					seq.init_phase = bpps_pkg::PH_INTERLOCK;
					nxt = bpps_pkg::ST_ERR;
				end else begin
					case (seq.init_phase)
						bpps_pkg::PH_INTERLOCK: begin
							act |= bpps_pkg::A_QUIT;
							if (t.interlock_tripped)
								nxt = bpps_pkg::ST_ERR;
							else
								seq.init_phase = bpps_pkg::PH_ADDRESS;
						end
						bpps_pkg::PH_ADDRESS: begin
							act |= bpps_pkg::A_ADDR;
							if (t.slaves_found == regs.expected_slaves)
								seq.init_phase = bpps_pkg::PH_SETUP;
						end
						bpps_pkg::PH_SETUP: begin
							act |= bpps_pkg::A_SETUP;
							seq.init_phase = bpps_pkg::PH_CAPACITY;
						end
						bpps_pkg::PH_CAPACITY: begin
							act |= bpps_pkg::A_CAP;
							if (t.measure_init_ok)
								seq.init_phase = bpps_pkg::PH_CALIBRATE;
						end
						bpps_pkg::PH_CALIBRATE: begin
							act |= bpps_pkg::A_CAL;
							if (t.calib_status == bpps_pkg::CAL_OK)
								seq.init_phase = bpps_pkg::PH_START;
							else if (t.calib_status != bpps_pkg::CAL_BUSY)
								nxt = bpps_pkg::ST_ERR;
						end
						bpps_pkg::PH_START: begin
							act |= bpps_pkg::A_TIMERS;
							if (t.timer_start_error || t.wheel_speed_error) begin
								nxt = bpps_pkg::ST_ERR;
							end else begin
								seq.init_phase = bpps_pkg::PH_INTERLOCK;
								nxt = bpps_pkg::ST_OFF;
							end
						end
						default: seq.init_phase = bpps_pkg::PH_INTERLOCK;
					endcase
				end
			end
		endcase

		seq.main = nxt;
		r.next_state = nxt;
		r.init_phase_out = seq.init_phase;
		r.action_mask = act;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= MISMATCH_REPORTS)
			$display("mismatch in %s of result %0d: expected %0h, got %0h",
				field, results_checked, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		bpps_pkg::result_t got;
		bpps_pkg::result_t want;
		bpps_pkg::tick_t   seen;

		if (!arst_n) begin
			regs.expected_slaves = bpps_pkg::RST_EXPECTED_SLAVES;
			regs.off_update_period_ms = bpps_pkg::RST_OFF_PERIOD;
			regs.precharge_time_ms = bpps_pkg::RST_PRECHARGE_TIME;
			regs.quit_error_time_ms = bpps_pkg::RST_QUIT_ERROR_TIME;
			seq = '0;
			seq.main = bpps_pkg::ST_INIT;
			seq.precharge_fresh = 1'b1;
			tick_outcomes_due.delete();
			mismatches = 0;
			results_checked = 0;
			outcomes_due = 0;
			switch_ons = 0;
			error_exits = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bpps_pkg::CFG_EXPECTED_SLAVES: regs.expected_slaves = cfg_data[5:0];
					bpps_pkg::CFG_OFF_PERIOD:      regs.off_update_period_ms = cfg_data;
					bpps_pkg::CFG_PRECHARGE_TIME:  regs.precharge_time_ms = cfg_data;
					bpps_pkg::CFG_QUIT_ERROR_TIME: regs.quit_error_time_ms = cfg_data;
					default: ;
				endcase
			end

			// a result never belongs to a tick taken at the same edge
			if (out_valid && out_ready) begin
				got = {shown_state, next_state, init_phase_out, action_mask};
				if (tick_outcomes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_REPORTS)
						$display("result %0h arrived with no tick outstanding", got);
				end else begin
					want = tick_outcomes_due.pop_front();
					if (got.shown_state !== want.shown_state)
						flag_mismatch("shown_state", 32'(want.shown_state),
							32'(got.shown_state));
					if (got.next_state !== want.next_state)
						flag_mismatch("next_state", 32'(want.next_state),
							32'(got.next_state));
					if (got.init_phase_out !== want.init_phase_out)
						flag_mismatch("init_phase_out", 32'(want.init_phase_out),
							32'(got.init_phase_out));
					if (got.action_mask !== want.action_mask)
						flag_mismatch("action_mask", 32'(want.action_mask),
							32'(got.action_mask));
				end
				results_checked++;
				if (got.shown_state == bpps_pkg::ST_PRE && got.next_state == bpps_pkg::ST_ON)
					switch_ons++;
				if ((got.action_mask & bpps_pkg::A_CLEAR) != '0)
					error_exits++;
			end

			if (in_valid && in_ready) begin
				seen = {now_ms, interlock_tripped, on_pin_level, off_pin_level, stale_data,
					stale_data_off, limit_faults, slaves_found, measure_init_ok,
					calib_status, timer_start_error, wheel_speed_error};
				tick_outcomes_due.push_back(step_sequencer(seen));
			end
			outcomes_due = tick_outcomes_due.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives run ticks into the power sequencer with random gaps and output
// stalls, walks init, error recovery and a precharge across the time wrap,
// then runs random bursts under several register settings; the checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned CYCLE_LIMIT       = 500000;
	localparam int unsigned SETTINGS_COUNT    = 6;
	localparam int unsigned TICKS_PER_SETTING = 155;
	localparam int unsigned LONG_HOLD_AFTER   = 300;
	localparam int unsigned LONG_HOLD_CYCLES  = 80;

	localparam logic [1:0] CAL_TIMEOUT   = 2'd2;
	localparam logic [1:0] CAL_HAL_ERROR = 2'd3;

	typedef enum logic [1:0] {
		BURST_HEALTHY,
		BURST_OFF_HELD,
		BURST_NOISE
	} burst_t;

	logic        clk;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] now_ms = '0;
	logic        interlock_tripped = 1'b0;
	logic        on_pin_level = 1'b0;
	logic        off_pin_level = 1'b1;
	logic        stale_data = 1'b0;
	logic        stale_data_off = 1'b0;
	logic [4:0]  limit_faults = '0;
	logic [5:0]  slaves_found = '0;
	logic        measure_init_ok = 1'b0;
	logic [1:0]  calib_status = bpps_pkg::CAL_BUSY;
	logic        timer_start_error = 1'b0;
	logic        wheel_speed_error = 1'b0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  shown_state;
	logic [2:0]  next_state;
	logic [2:0]  init_phase_out;
	logic [12:0] action_mask;

	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int unsigned mismatches;
	int unsigned results_checked;
	int unsigned outcomes_due;
	int unsigned switch_ons;
	int unsigned error_exits;

	bpps_pkg::cfg_t active_cfg;
	logic [31:0]    clock_ms;
	int unsigned    step_max;
	int unsigned    send_calm = 0;
	int unsigned    ticks_sent = 0;

	battery_pack_power_sequencer u_top (.*);

	bpps_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly short idle stretches, now and then a long one
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] pick_time_ms();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(1, 300));
	endfunction

	function automatic bpps_pkg::tick_t calm_tick(input logic [31:0] at_ms);
		bpps_pkg::tick_t t;

		t = '0;
		t.now_ms = at_ms;
		t.off_pin_level = 1'b1;
		t.calib_status = bpps_pkg::CAL_BUSY;
		return t;
	endfunction

	function automatic bpps_pkg::tick_t make_tick(input burst_t mode);
		bpps_pkg::tick_t t;
		int unsigned     r;

		r = $urandom_range(0, 19);
		if (r == 19)
			clock_ms += $urandom();
		else if (r == 18)
			clock_ms += 2 * step_max + $urandom_range(0, step_max);
		else if (r >= 2)
			clock_ms += $urandom_range(0, step_max);

		t = calm_tick(clock_ms);
		t.interlock_tripped = ($urandom_range(0, 59) == 0);
		t.on_pin_level = ($urandom_range(0, 1) == 1);
		t.off_pin_level = ($urandom_range(0, 15) != 0);
		t.stale_data = ($urandom_range(0, 49) == 0);
		t.stale_data_off = ($urandom_range(0, 49) == 0);
		if ($urandom_range(0, 39) == 0)
			t.limit_faults = 5'($urandom_range(1, 31));
		t.slaves_found = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
			: active_cfg.expected_slaves;
		t.measure_init_ok = ($urandom_range(0, 2) != 0);
		r = $urandom_range(0, 19);
		t.calib_status = (r < 6) ? bpps_pkg::CAL_BUSY : (r < 18) ? bpps_pkg::CAL_OK
			: (r == 18) ? CAL_TIMEOUT : CAL_HAL_ERROR;
		t.timer_start_error = ($urandom_range(0, 29) == 0);
		t.wheel_speed_error = ($urandom_range(0, 29) == 0);

		if (mode == BURST_OFF_HELD) begin
			t.off_pin_level = 1'b0;
		end else if (mode == BURST_NOISE) begin
			t.interlock_tripped = ($urandom_range(0, 1) == 1);
			t.off_pin_level = ($urandom_range(0, 1) == 1);
			t.stale_data = ($urandom_range(0, 1) == 1);
			t.stale_data_off = ($urandom_range(0, 1) == 1);
			t.limit_faults = 5'($urandom_range(0, 31));
			t.slaves_found = 6'($urandom_range(0, 63));
			t.measure_init_ok = ($urandom_range(0, 1) == 1);
			t.calib_status = 2'($urandom_range(0, 3));
			t.timer_start_error = ($urandom_range(0, 1) == 1);
			t.wheel_speed_error = ($urandom_range(0, 1) == 1);
		end
		return t;
	endfunction

	// called at a rising edge, returns at the edge of the transfer
	task automatic offer_tick(input bpps_pkg::tick_t t);
		int unsigned gap;
		logic        took;

		gap = 0;
		if (send_calm != 0)
			send_calm--;
		else if ($urandom_range(0, 2) == 0)
			gap = idle_len();
		else if ($urandom_range(0, 40) == 0)
			send_calm = $urandom_range(20, 60);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{now_ms, interlock_tripped, on_pin_level, off_pin_level, stale_data, stale_data_off,
			limit_faults, slaves_found, measure_init_ok, calib_status, timer_start_error,
			wheel_speed_error} <= t;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		ticks_sent++;
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// drop valid and wait until every result is out
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outcomes_due != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin : watchdog
		int unsigned cycles;

		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timed out with %0d results outstanding", outcomes_due);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int unsigned stall_left;
		int unsigned calm_left;
		logic        long_hold_done;

		stall_left = 0;
		calm_left = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				// one long hold so the output buffer fills and input backs up
				if (!long_hold_done && results_checked >= LONG_HOLD_AFTER) begin
					long_hold_done = 1'b1;
					stall_left = LONG_HOLD_CYCLES;
				end else if (calm_left != 0) begin
					calm_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = idle_len();
				end else if ($urandom_range(0, 40) == 0) begin
					calm_left = $urandom_range(20, 80);
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		bpps_pkg::tick_t t;
		bpps_pkg::cfg_t  setting;
		burst_t          mode;
		int unsigned     burst_left;
		int unsigned     r;
		int unsigned     p;
		int unsigned     k;
		logic [15:0]     longest;

		burst_left = 0;
		mode = BURST_HEALTHY;
		active_cfg = {bpps_pkg::RST_EXPECTED_SLAVES, bpps_pkg::RST_OFF_PERIOD,
			bpps_pkg::RST_PRECHARGE_TIME, bpps_pkg::RST_QUIT_ERROR_TIME};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// interlock in the first init phase: quit strobe, then error
		t = calm_tick(32'd0);
		t.interlock_tripped = 1'b1;
		offer_tick(t);
		// hold the off button past the quit time
		t = calm_tick(32'd0);
		t.off_pin_level = 1'b0;
		offer_tick(t);
		t.now_ms = 32'd3001;
		offer_tick(t);
		t = calm_tick(32'd3002);
		offer_tick(t);
		t.slaves_found = 6'd63;
		offer_tick(t);
		// interlock later in init drops back to the first phase
		t.interlock_tripped = 1'b1;
		offer_tick(t);
		// hold flag survived leaving error, old start time is reused
		t = calm_tick(32'd7000);
		t.off_pin_level = 1'b0;
		offer_tick(t);
		t = calm_tick(32'd7001);
		offer_tick(t);
		t.slaves_found = bpps_pkg::RST_EXPECTED_SLAVES;
		offer_tick(t);
		t = calm_tick(32'd7002);
		offer_tick(t);
		t.measure_init_ok = 1'b1;
		offer_tick(t);
		// calibration failures keep the init phase
		t = calm_tick(32'd7003);
		t.calib_status = CAL_HAL_ERROR;
		offer_tick(t);
		t = calm_tick(32'd7100);
		t.off_pin_level = 1'b0;
		offer_tick(t);
		t = calm_tick(32'd7101);
		t.calib_status = CAL_TIMEOUT;
		offer_tick(t);
		t = calm_tick(32'd7200);
		t.off_pin_level = 1'b0;
		offer_tick(t);
		t = calm_tick(32'd7201);
		t.calib_status = bpps_pkg::CAL_OK;
		offer_tick(t);
		t = calm_tick(32'd7202);
		t.timer_start_error = 1'b1;
		offer_tick(t);
		t = calm_tick(32'd7300);
		t.off_pin_level = 1'b0;
		offer_tick(t);
		t = calm_tick(32'd7301);
		t.wheel_speed_error = 1'b1;
		offer_tick(t);
		t = calm_tick(32'd7400);
		t.off_pin_level = 1'b0;
		offer_tick(t);
		t = calm_tick(32'hFFFF_FFFE);
		offer_tick(t);
		// off to precharge, precharge time measured across the wrap
		t = calm_tick(32'hFFFF_FFFF);
		t.on_pin_level = 1'b1;
		offer_tick(t);
		offer_tick(t);
		t.now_ms = 32'h0000_07CF;
		offer_tick(t);
		t.now_ms = 32'h0000_07D0;
		offer_tick(t);
		// all limit faults while on
		t.limit_faults = 5'h1F;
		offer_tick(t);

		for (p = 0; p < SETTINGS_COUNT; p++) begin
			settle();
			if (p == 0) begin
				setting = {6'd1, 16'd1, 16'd1, 16'd1};
			end else if (p == 1) begin
				setting = {6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			end else begin
				setting.expected_slaves = 6'($urandom_range(1, 63));
				setting.off_update_period_ms = pick_time_ms();
				setting.precharge_time_ms = pick_time_ms();
				setting.quit_error_time_ms = pick_time_ms();
			end
			write_reg(bpps_pkg::CFG_EXPECTED_SLAVES, {10'd0, setting.expected_slaves});
			write_reg(bpps_pkg::CFG_OFF_PERIOD, setting.off_update_period_ms);
			write_reg(bpps_pkg::CFG_PRECHARGE_TIME, setting.precharge_time_ms);
			write_reg(bpps_pkg::CFG_QUIT_ERROR_TIME, setting.quit_error_time_ms);
			cfg_we <= 1'b0;
			active_cfg = setting;

			// time steps scaled so precharge and error hold resolve in a few ticks
			longest = setting.off_update_period_ms;
			if (setting.precharge_time_ms > longest)
				longest = setting.precharge_time_ms;
			if (setting.quit_error_time_ms > longest)
				longest = setting.quit_error_time_ms;
			step_max = longest / 3 + 1;
			clock_ms = $urandom();

			for (k = 0; k < TICKS_PER_SETTING; k++) begin
				if (burst_left == 0) begin
					r = $urandom_range(0, 19);
					mode = (r < 13) ? BURST_HEALTHY : (r < 17) ? BURST_OFF_HELD : BURST_NOISE;
					burst_left = $urandom_range(5, 30);
				end
				burst_left--;
				offer_tick(make_tick(mode));
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d ticks under %0d register settings after the reset values",
			ticks_sent, SETTINGS_COUNT);
		$display("%0d results checked, %0d switch-ons from precharge, %0d error exits",
			results_checked, switch_ons, error_exits);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
